@@ hdl/epoch_to_utc_calendar_assert.svh @@
// Assertion macros used by the calendar converter core.
`ifndef EPOCH_TO_UTC_CALENDAR_ASSERT_SVH
`define EPOCH_TO_UTC_CALENDAR_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define E2U_CHECK(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its trigger.
`define E2U_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A consequence that must hold in the cycle after its trigger.
`define E2U_IMPLIES_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/e2u_pkg.sv @@
// Shared types, constants and calendar tables for the epoch to UTC converter.
package e2u_pkg;

    localparam int EPOCH_W     = 32;
    localparam int ALU_W       = 16;   // wide enough for the whole-day count
    localparam int REM_W       = 6;    // largest divisor is 60

    localparam logic [7:0] EPOCH_YEAR_OFS = 8'd70;   // 1970 minus 1900
    localparam logic [6:0] EPOCH_MOD100   = 7'd70;   // 1970 mod 100
    localparam logic [8:0] EPOCH_MOD400   = 9'd370;  // 1970 mod 400
    localparam logic [6:0] CENTURY_LAST   = 7'd99;
    localparam logic [8:0] QUAD_LAST      = 9'd399;
    localparam logic [15:0] EPOCH_WEEKDAY = 16'd4;   // 1970-01-01 was a Thursday

    localparam logic [8:0] DAYS_COMMON = 9'd365;
    localparam logic [8:0] DAYS_LEAP   = 9'd366;
    localparam logic [8:0] DOY_MAX     = 9'd365;
    localparam logic [7:0] YEAR_MAX    = 8'd206;

    localparam logic [3:0] MONTH_FEB  = 4'd1;
    localparam logic [3:0] MONTH_LAST = 4'd11;

    // Divide passes of the sequencer: seconds, minutes, hours, weekday.
    typedef enum logic [1:0] {
        PH_SEC  = 2'd0,
        PH_MIN  = 2'd1,
        PH_HOUR = 2'd2,
        PH_WDAY = 2'd3
    } phase_t;

    typedef struct packed {
        logic [5:0] second_of_minute;
        logic [5:0] minute_of_hour;
        logic [4:0] hour_of_day;
        logic [4:0] day_of_month;
        logic [3:0] month_index;
        logic [7:0] years_since_1900;
        logic [2:0] weekday;
        logic [8:0] day_of_year;
    } result_t;

    function automatic logic [REM_W-1:0] divisor_of(input phase_t ph);
        logic [REM_W-1:0] d;
        case (ph)
            PH_SEC:  d = 6'd60;
            PH_MIN:  d = 6'd60;
            PH_HOUR: d = 6'd24;
            PH_WDAY: d = 6'd7;
            default: d = 6'd60;
        endcase
        return d;
    endfunction

    // Scaled reciprocals. The seconds and minutes passes multiply the dividend over four
    // by the reciprocal of 15 and keep bits from 35 up, the hour pass the dividend over
    // eight by the reciprocal of 3 from bit 33 up, and the weekday pass the day count by
    // the reciprocal of 7 from bit 19 up. Each quotient is exact over its input range.
    function automatic logic [EPOCH_W-1:0] magic_of(input phase_t ph);
        logic [EPOCH_W-1:0] m;
        case (ph)
            PH_SEC:  m = 32'h8888_8889;
            PH_MIN:  m = 32'h8888_8889;
            PH_HOUR: m = 32'hAAAA_AAAB;
            PH_WDAY: m = 32'h0001_2493;
            default: m = 32'h8888_8889;
        endcase
        return m;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] mo, input logic leap);
        logic [4:0] n;
        case (mo)
            4'd0:    n = 5'd31;
            4'd1:    n = leap ? 5'd29 : 5'd28;
            4'd2:    n = 5'd31;
            4'd3:    n = 5'd30;
            4'd4:    n = 5'd31;
            4'd5:    n = 5'd30;
            4'd6:    n = 5'd31;
            4'd7:    n = 5'd31;
            4'd8:    n = 5'd30;
            4'd9:    n = 5'd31;
            4'd10:   n = 5'd30;
            default: n = 5'd31;
        endcase
        return n;
    endfunction

endpackage

@@ hdl/e2u_in_if.sv @@
// Input channel carrying one epoch second count per beat.
interface e2u_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] epoch_seconds;

    modport source (output valid, output epoch_seconds, input ready);
    modport sink   (input valid, input epoch_seconds, output ready);
endinterface

@@ hdl/e2u_out_if.sv @@
// Output channel carrying one broken-down UTC date and time per beat.
interface e2u_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] second_of_minute;
    logic [5:0] minute_of_hour;
    logic [4:0] hour_of_day;
    logic [4:0] day_of_month;
    logic [3:0] month_index;
    logic [7:0] years_since_1900;
    logic [2:0] weekday;
    logic [8:0] day_of_year;

    modport source (output valid, output second_of_minute, output minute_of_hour,
                    output hour_of_day, output day_of_month, output month_index,
                    output years_since_1900, output weekday, output day_of_year,
                    input ready);
    modport sink   (input valid, input second_of_minute, input minute_of_hour,
                    input hour_of_day, input day_of_month, input month_index,
                    input years_since_1900, input weekday, input day_of_year,
                    output ready);
endinterface

@@ hdl/e2u_alu.sv @@
// Compare and subtract unit used by the year walk and the month walk of the sequencer.
module e2u_alu (
    input  logic [e2u_pkg::ALU_W-1:0] a,
    input  logic [e2u_pkg::ALU_W-1:0] b,
    output logic                      ge,
    output logic [e2u_pkg::ALU_W-1:0] diff
);
    logic [e2u_pkg::ALU_W:0] wide;

    // The borrow out of the subtraction doubles as the compare result.
    assign wide = {1'b0, a} - {1'b0, b};
    assign ge   = ~wide[e2u_pkg::ALU_W];
    assign diff = wide[e2u_pkg::ALU_W-1:0];
endmodule

@@ hdl/e2u_core.sv @@
// Sequencer and datapath that run the divides, the year walk and the month walk.
`include "epoch_to_utc_calendar_assert.svh"

module e2u_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [e2u_pkg::EPOCH_W-1:0] epoch,
    input  logic                        take,
    output logic                        idle,
    output logic                        done,
    output e2u_pkg::result_t            result
);
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MUL   = 6'b000010,
        ST_REM   = 6'b000100,
        ST_YEAR  = 6'b001000,
        ST_MONTH = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    e2u_pkg::phase_t phase_reg, phase_next;
    logic [e2u_pkg::EPOCH_W-1:0] work_reg, work_next;
    logic [e2u_pkg::EPOCH_W-1:0] quot_reg, quot_next;
    logic [e2u_pkg::ALU_W-1:0]   days_reg, days_next;
    logic [5:0] sec_reg, sec_next;
    logic [5:0] min_reg, min_next;
    logic [4:0] hour_reg, hour_next;
    logic [2:0] wday_reg, wday_next;
    logic [7:0] year_reg, year_next;
    logic [6:0] mod100_reg, mod100_next;
    logic [8:0] mod400_reg, mod400_next;
    logic [8:0] doy_reg, doy_next;
    logic [3:0] mon_reg, mon_next;

    logic [e2u_pkg::ALU_W-1:0]     alu_a, alu_b, alu_diff;
    logic                          alu_ge;
    logic [e2u_pkg::EPOCH_W-1:0]   mul_a, mul_b;
    logic [2*e2u_pkg::EPOCH_W-1:0] product;
    logic [e2u_pkg::EPOCH_W-1:0]   quot_calc;
    logic [e2u_pkg::REM_W-1:0]     rem_calc;
    logic                          leap;

    e2u_alu u_alu (
        .a    (alu_a),
        .b    (alu_b),
        .ge   (alu_ge),
        .diff (alu_diff)
    );

    // Years are kept as an offset from 1900, which is itself a multiple of four.
    assign leap = (year_reg[1:0] == 2'd0)
                  && ((mod100_reg != 7'd0) || (mod400_reg == 9'd0));

    always_comb
    begin
        case (state_reg)
            ST_YEAR:
            begin
                alu_a = days_reg;
                alu_b = e2u_pkg::ALU_W'(leap ? e2u_pkg::DAYS_LEAP : e2u_pkg::DAYS_COMMON);
            end
            ST_MONTH:
            begin
                alu_a = days_reg;
                alu_b = e2u_pkg::ALU_W'(e2u_pkg::month_len(mon_reg, leap));
            end
            default:
            begin
                alu_a = days_reg;
                alu_b = '0;
            end
        endcase
    end

    // Divide by 60 is divide by 4 then by 15, divide by 24 is divide by 8 then by 3.
    always_comb
    begin
        case (phase_reg)
            e2u_pkg::PH_HOUR: mul_a = {3'b000, work_reg[e2u_pkg::EPOCH_W-1:3]};
            e2u_pkg::PH_WDAY: mul_a = work_reg;
            default:          mul_a = {2'b00, work_reg[e2u_pkg::EPOCH_W-1:2]};
        endcase
    end

    assign mul_b   = e2u_pkg::magic_of(phase_reg);
    assign product = {32'd0, mul_a} * {32'd0, mul_b};

    always_comb
    begin
        case (phase_reg)
            e2u_pkg::PH_HOUR: quot_calc = {1'b0, product[63:33]};
            e2u_pkg::PH_WDAY: quot_calc = product[50:19];
            default:          quot_calc = {3'b000, product[63:35]};
        endcase
    end

    // The remainder is below 64, so six bits of the dividend and the product suffice.
    assign rem_calc = work_reg[e2u_pkg::REM_W-1:0]
                      - e2u_pkg::REM_W'(quot_reg[e2u_pkg::REM_W-1:0]
                                        * e2u_pkg::divisor_of(phase_reg));

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        work_next   = work_reg;
        quot_next   = quot_reg;
        days_next   = days_reg;
        sec_next    = sec_reg;
        min_next    = min_reg;
        hour_next   = hour_reg;
        wday_next   = wday_reg;
        year_next   = year_reg;
        mod100_next = mod100_reg;
        mod400_next = mod400_reg;
        doy_next    = doy_reg;
        mon_next    = mon_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    work_next  = epoch;
                    phase_next = e2u_pkg::PH_SEC;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                quot_next  = quot_calc;
                state_next = ST_REM;
            end
            ST_REM:
            begin
                work_next  = quot_reg;
                state_next = ST_MUL;
                case (phase_reg)
                    e2u_pkg::PH_SEC:
                    begin
                        sec_next   = rem_calc;
                        phase_next = e2u_pkg::PH_MIN;
                    end
                    e2u_pkg::PH_MIN:
                    begin
                        min_next   = rem_calc;
                        phase_next = e2u_pkg::PH_HOUR;
                    end
                    e2u_pkg::PH_HOUR:
                    begin
                        // The quotient is the whole-day count; the weekday pass
                        // divides an offset copy and leaves it intact.
                        hour_next  = rem_calc[4:0];
                        days_next  = quot_reg[e2u_pkg::ALU_W-1:0];
                        work_next  = e2u_pkg::EPOCH_W'(quot_reg[e2u_pkg::ALU_W-1:0]
                                                       + e2u_pkg::EPOCH_WEEKDAY);
                        phase_next = e2u_pkg::PH_WDAY;
                    end
                    default:
                    begin
                        wday_next   = rem_calc[2:0];
                        year_next   = e2u_pkg::EPOCH_YEAR_OFS;
                        mod100_next = e2u_pkg::EPOCH_MOD100;
                        mod400_next = e2u_pkg::EPOCH_MOD400;
                        state_next  = ST_YEAR;
                    end
                endcase
            end
            ST_YEAR:
            begin
                if (alu_ge)
                begin
                    days_next   = alu_diff;
                    year_next   = year_reg + 1'b1;
                    mod100_next = (mod100_reg == e2u_pkg::CENTURY_LAST) ? '0
                                                                        : mod100_reg + 1'b1;
                    mod400_next = (mod400_reg == e2u_pkg::QUAD_LAST) ? '0
                                                                     : mod400_reg + 1'b1;
                end
                else
                begin
                    doy_next   = days_reg[8:0];
                    mon_next   = '0;
                    state_next = ST_MONTH;
                end
            end
            ST_MONTH:
            begin
                if (alu_ge && (mon_reg != e2u_pkg::MONTH_LAST))
                begin
                    days_next = alu_diff;
                    mon_next  = mon_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= e2u_pkg::PH_SEC;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg   <= work_next;
        quot_reg   <= quot_next;
        days_reg   <= days_next;
        sec_reg    <= sec_next;
        min_reg    <= min_next;
        hour_reg   <= hour_next;
        wday_reg   <= wday_next;
        year_reg   <= year_next;
        mod100_reg <= mod100_next;
        mod400_reg <= mod400_next;
        doy_reg    <= doy_next;
        mon_reg    <= mon_next;
    end

    assign idle = (state_reg == ST_IDLE);
    assign done = (state_reg == ST_DONE);

    always_comb
    begin
        result.second_of_minute = sec_reg;
        result.minute_of_hour   = min_reg;
        result.hour_of_day      = hour_reg;
        result.day_of_month     = days_reg[4:0] + 5'd1;
        result.month_index      = mon_reg;
        result.years_since_1900 = year_reg;
        result.weekday          = wday_reg;
        result.day_of_year      = doy_reg;
    end

    `E2U_IMPLIES(a_rem_below_divisor, state_reg == ST_REM,
        rem_calc < e2u_pkg::divisor_of(phase_reg), "divide remainder reached its divisor")
    `E2U_IMPLIES(a_year_counters, state_reg == ST_YEAR,
        (year_reg <= e2u_pkg::YEAR_MAX) && (mod100_reg <= e2u_pkg::CENTURY_LAST)
        && (mod400_reg <= e2u_pkg::QUAD_LAST), "year walk ran past its range")
    `E2U_IMPLIES(a_month_days, state_reg == ST_MONTH,
        (days_reg <= e2u_pkg::ALU_W'(e2u_pkg::DOY_MAX)) && (mon_reg <= e2u_pkg::MONTH_LAST),
        "month walk started with more than a year of days")
    `E2U_IMPLIES_NEXT(a_done_holds, (state_reg == ST_DONE) && !take,
        state_reg == ST_DONE, "finished result dropped before it was taken")
endmodule

@@ hdl/epoch_to_utc_calendar.sv @@
// Top level of the epoch seconds to UTC calendar converter.
// Converts an unsigned 32-bit count of seconds since 1970-01-01 00:00:00 UTC into the
// proleptic Gregorian date and time, one beat at a time. The divides by 60, 60 and 24 and
// the mod 7 for the weekday each take a reciprocal multiply step and a remainder step.
// A compare and subtract unit then walks the years from 1970 and then the months. The
// sequencer holds the finished result until the output register is free to take it.
// The input is ready only while the sequencer is idle; the result sits in an output
// register, so a new beat is taken while an earlier result still waits downstream.
module epoch_to_utc_calendar (
    input logic         clk,
    input logic         rst_n,
    e2u_in_if.sink      sample,
    e2u_out_if.source   calendar
);
    logic             core_idle;
    logic             core_done;
    logic             load;
    e2u_pkg::result_t core_result;
    e2u_pkg::result_t out_reg;
    logic             out_valid_reg, out_valid_next;

    assign sample.ready = core_idle;
    assign load         = core_done && (!out_valid_reg || calendar.ready);

    e2u_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (sample.valid),
        .epoch  (sample.epoch_seconds),
        .take   (load),
        .idle   (core_idle),
        .done   (core_done),
        .result (core_result)
    );

    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (calendar.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= core_result;
        end
    end

    assign calendar.valid            = out_valid_reg;
    assign calendar.second_of_minute = out_reg.second_of_minute;
    assign calendar.minute_of_hour   = out_reg.minute_of_hour;
    assign calendar.hour_of_day      = out_reg.hour_of_day;
    assign calendar.day_of_month     = out_reg.day_of_month;
    assign calendar.month_index      = out_reg.month_index;
    assign calendar.years_since_1900 = out_reg.years_since_1900;
    assign calendar.weekday          = out_reg.weekday;
    assign calendar.day_of_year      = out_reg.day_of_year;
endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the epoch seconds to UTC calendar converter.
`timescale 1ns / 1ps

module testbench;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 300;
    localparam int RANDOM_ITEMS   = 550;
    localparam int SECS_PER_DAY   = 86400;

    typedef struct {
        logic [31:0]      secs;
        bit               typed;
        e2u_pkg::result_t cal;
    } stim_row_t;

    typedef struct {
        logic [31:0]      secs;
        e2u_pkg::result_t cal;
    } pending_t;

    logic clk;
    logic rst_n;

    e2u_in_if  sample_if ();
    e2u_out_if calendar_if ();

    epoch_to_utc_calendar dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .sample   (sample_if),
        .calendar (calendar_if)
    );

    pending_t  calendar_due[$];
    stim_row_t directed_rows[$];
    int        error_count;
    int        send_idle_pct;
    int        recv_idle_pct;
    int        stall_cycles;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic bit leap_year(input int unsigned yr);
        return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    endfunction

    function automatic int unsigned days_in_month(input int unsigned mo, input int unsigned yr);
        int unsigned n;
        case (mo)
            1:       n = leap_year(yr) ? 29 : 28;
            3, 5, 8, 10: n = 30;
            default: n = 31;
        endcase
        return n;
    endfunction

    // Breaks a second count down into the calendar fields the block reports.
    function automatic e2u_pkg::result_t civil_time_of(input logic [31:0] secs);
        e2u_pkg::result_t r;
        int unsigned      rest;
        int unsigned      yr;
        int unsigned      mo;
        rest = secs;
        r.second_of_minute = 6'(rest % 60);
        rest = rest / 60;
        r.minute_of_hour = 6'(rest % 60);
        rest = rest / 60;
        r.hour_of_day = 5'(rest % 24);
        rest = rest / 24;
        // 1970-01-01 fell on a Thursday.
        r.weekday = 3'((rest + 4) % 7);
        yr = 1970;
        while (rest >= (leap_year(yr) ? 366 : 365))
        begin
            rest = rest - (leap_year(yr) ? 366 : 365);
            yr++;
        end
        r.day_of_year = 9'(rest);
        mo = 0;
        while (mo < 11 && rest >= days_in_month(mo, yr))
        begin
            rest = rest - days_in_month(mo, yr);
            mo++;
        end
        r.day_of_month     = 5'(rest + 1);
        r.month_index      = 4'(mo);
        r.years_since_1900 = 8'(yr - 1900);
        return r;
    endfunction

    function automatic longint year_start_secs(input int unsigned yr);
        longint days;
        days = 0;
        for (int unsigned y = 1970; y < yr; y++)
            days += leap_year(y) ? 366 : 365;
        return days * SECS_PER_DAY;
    endfunction

    // Random counts, most of them crowded around year, month and range boundaries.
    function automatic logic [31:0] pick_epoch();
        int unsigned yr;
        longint      base;
        longint      delta;
        yr    = $urandom_range(2106, 1970);
        delta = longint'($urandom_range(200000)) - 100000;
        case ($urandom_range(5))
            0, 1: return $urandom;
            2:    return $urandom_range(1 << 20);
            3:    base = year_start_secs(yr);
            4:    base = year_start_secs(yr) + (leap_year(yr) ? 60 : 59) * SECS_PER_DAY;
            default: return 32'hFFFF_FFFF - $urandom_range(100000);
        endcase
        return 32'(base + delta);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input logic [31:0] secs, input string name,
                               input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("epoch %0d %s got %0d want %0d", secs, name, got, want));
    endtask

    function automatic void add_row(input logic [31:0] secs, input bit typed,
                                    input e2u_pkg::result_t cal);
        stim_row_t row;
        row.secs  = secs;
        row.typed = typed;
        row.cal   = cal;
        directed_rows.push_back(row);
    endfunction

    task automatic send_epoch(input logic [31:0] secs, input bit typed,
                              input e2u_pkg::result_t cal);
        pending_t p;
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_if.valid <= 1'b0;
            @(posedge clk);
        end
        sample_if.valid         <= 1'b1;
        sample_if.epoch_seconds <= secs;
        do
            @(posedge clk);
        while (!sample_if.ready);
        p.secs = secs;
        p.cal  = typed ? cal : civil_time_of(secs);
        calendar_due.push_back(p);
    endtask

    // The sender holds off until every outstanding result has come back.
    task automatic drain_results();
        sample_if.valid <= 1'b0;
        while (calendar_due.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            calendar_if.ready <= 1'b0;
        end
        else
        begin
            if (calendar_if.valid && calendar_if.ready)
            begin
                if (calendar_due.size() == 0)
                begin
                    report_mismatch("result beat with nothing expected");
                end
                else
                begin
                    pending_t p;
                    p = calendar_due.pop_front();
                    check_field(p.secs, "second_of_minute", calendar_if.second_of_minute,
                                p.cal.second_of_minute);
                    check_field(p.secs, "minute_of_hour", calendar_if.minute_of_hour,
                                p.cal.minute_of_hour);
                    check_field(p.secs, "hour_of_day", calendar_if.hour_of_day,
                                p.cal.hour_of_day);
                    check_field(p.secs, "day_of_month", calendar_if.day_of_month,
                                p.cal.day_of_month);
                    check_field(p.secs, "month_index", calendar_if.month_index,
                                p.cal.month_index);
                    check_field(p.secs, "years_since_1900", calendar_if.years_since_1900,
                                p.cal.years_since_1900);
                    check_field(p.secs, "weekday", calendar_if.weekday, p.cal.weekday);
                    check_field(p.secs, "day_of_year", calendar_if.day_of_year,
                                p.cal.day_of_year);
                end
            end
            calendar_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (sample_if.valid && sample_if.ready)
                   || (calendar_if.valid && calendar_if.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** epoch_to_utc_calendar: FAILED **");
            $finish;
        end
    end

    initial
    begin
        error_count   = 0;
        send_idle_pct = 30;
        recv_idle_pct = 52;
        rst_n                   <= 1'b0;
        sample_if.valid         <= 1'b0;
        sample_if.epoch_seconds <= '0;

        // Epoch start, both ends of the range and the first day boundary are typed in.
        add_row(32'd0, 1'b1, {6'd0, 6'd0, 5'd0, 5'd1, 4'd0, 8'd70, 3'd4, 9'd0});
        add_row(32'hFFFF_FFFF, 1'b1, {6'd15, 6'd28, 5'd6, 5'd7, 4'd1, 8'd206, 3'd0, 9'd37});
        add_row(32'd59, 1'b1, {6'd59, 6'd0, 5'd0, 5'd1, 4'd0, 8'd70, 3'd4, 9'd0});
        add_row(32'd86399, 1'b1, {6'd59, 6'd59, 5'd23, 5'd1, 4'd0, 8'd70, 3'd4, 9'd0});
        add_row(32'd86400, 1'b1, {6'd0, 6'd0, 5'd0, 5'd2, 4'd0, 8'd70, 3'd5, 9'd1});
        // Leap days, leap-year ends and the century years on either side of the rule.
        add_row(32'd60, 1'b0, '0);
        add_row(32'd3599, 1'b0, '0);
        add_row(32'd68169600, 1'b0, '0);
        add_row(32'd94607999, 1'b0, '0);
        add_row(32'd946684799, 1'b0, '0);
        add_row(32'd946684800, 1'b0, '0);
        add_row(32'd951782400, 1'b0, '0);
        add_row(32'd978307199, 1'b0, '0);
        add_row(32'h7FFF_FFFF, 1'b0, '0);
        add_row(32'h8000_0000, 1'b0, '0);
        add_row(32'h5555_5555, 1'b0, '0);
        add_row(32'hAAAA_AAAA, 1'b0, '0);
        add_row(32'd4102444799, 1'b0, '0);
        add_row(32'd4102444800, 1'b0, '0);
        add_row(32'(year_start_secs(2100) + 59 * SECS_PER_DAY - 1), 1'b0, '0);
        add_row(32'(year_start_secs(2100) + 59 * SECS_PER_DAY), 1'b0, '0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_epoch(directed_rows[i].secs, directed_rows[i].typed, directed_rows[i].cal);
        drain_results();

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 30;
                    recv_idle_pct = 52;
                end
                1:
                begin
                    send_idle_pct = 52;
                    recv_idle_pct = 30;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < RANDOM_ITEMS / 3; n++)
                send_epoch(pick_epoch(), 1'b0, '0);
            drain_results();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (calendar_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", calendar_due.size()));
        if (error_count == 0)
            $display("** epoch_to_utc_calendar: PASSED **");
        else
            $display("** epoch_to_utc_calendar: FAILED **");
        $finish;
    end

endmodule
